FILE: src/vt52_text_terminal_core_top_macros.svh
// ----------------------------------------------------------------------------
// VT52 terminal core assertion macros
// Shared assertion shorthands; the user module must have i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef VT52_TEXT_TERMINAL_CORE_TOP_MACROS_SVH
`define VT52_TEXT_TERMINAL_CORE_TOP_MACROS_SVH

// same-cycle implication
`define VT52TC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VT52TC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/vt52tc_pkg.sv
// ----------------------------------------------------------------------------
// vt52tc_pkg
// Screen geometry, character codes, escape phases and shared types.
// ----------------------------------------------------------------------------
package vt52tc_pkg;

    localparam int ROWS   = 32;
    localparam int COLS   = 64;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int CHAR_W = 7;
    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_row  ROW_LAST  = t_row'(ROWS - 1);
    localparam t_col  COL_LAST  = t_col'(COLS - 1);
    localparam t_addr ADDR_LAST = t_addr'(DEPTH - 1);
    localparam t_addr LAST_ROW_BASE = t_addr'((ROWS - 1) * COLS);

    // escape phase codes (also the escape_phase output)
    localparam logic [1:0] ESC_NORMAL = 2'd0;
    localparam logic [1:0] ESC_START  = 2'd1;
    localparam logic [1:0] ESC_ROW    = 2'd2;
    localparam logic [1:0] ESC_COL    = 2'd3;

    // character codes
    localparam t_char CH_BS    = 7'h08;
    localparam t_char CH_TAB   = 7'h09;
    localparam t_char CH_LF    = 7'h0a;
    localparam t_char CH_CR    = 7'h0d;
    localparam t_char CH_ESC   = 7'h1b;
    localparam t_char CH_SPACE = 7'h20;
    localparam t_char CH_DEL   = 7'h7f;
    localparam t_char CH_UP    = 7'h41; // 'A'
    localparam t_char CH_DOWN  = 7'h42; // 'B'
    localparam t_char CH_RIGHT = 7'h43; // 'C'
    localparam t_char CH_LEFT  = 7'h44; // 'D'
    localparam t_char CH_HOME  = 7'h48; // 'H'
    localparam t_char CH_ERS_S = 7'h4a; // 'J'
    localparam t_char CH_ERS_L = 7'h4b; // 'K'
    localparam t_char CH_ADDR  = 7'h59; // 'Y'

    localparam logic [7:0] ADDR_BIAS = 8'd31;
    localparam logic [6:0] TAB_MASK  = 7'h78;
    localparam logic [6:0] TAB_STEP  = 7'd8;

    // one memory port set: one write, one read
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_char wdata;
        t_addr raddr;
    } t_mem_port;

    // block move then block clear
    typedef struct packed {
        logic  copy_en;
        t_addr copy_lo;   // first source address
        t_addr copy_hi;   // last source address
        t_addr offset;    // destination = source - offset
        t_addr zero_lo;
        t_addr zero_hi;
    } t_sweep_req;

    // effect of one character
    typedef struct packed {
        t_row       row;
        t_col       col;
        logic [1:0] esc;
        logic       wr;
        logic       sweep;
        t_sweep_req req;
    } t_step;

    function automatic t_addr cell_addr(input t_row r, input t_col c);
        cell_addr = t_addr'(t_addr'(r) * t_addr'(COLS)) + t_addr'(c);
    endfunction

endpackage

FILE: src/vt52tc_if.sv
// ----------------------------------------------------------------------------
// vt52tc channel interfaces
// Valid/ready channels for the command words and the result words.
// ----------------------------------------------------------------------------
interface vt52tc_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [5:0] read_col;

    modport source (output valid, cmd, char_code, read_row, read_col, input ready);
    modport sink   (input valid, cmd, char_code, read_row, read_col, output ready);
endinterface

interface vt52tc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic [6:0] cell_data;
    logic [1:0] escape_phase;

    modport source (output valid, cursor_row, cursor_col, cell_data, escape_phase,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_data, escape_phase,
                    output ready);
endinterface

FILE: src/vt52tc_ram.sv
// ----------------------------------------------------------------------------
// vt52tc_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module vt52tc_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/vt52tc_decode.sv
// ----------------------------------------------------------------------------
// vt52tc_decode
// Character decode: next cursor, escape phase, cell write and block request.
// ----------------------------------------------------------------------------
module vt52tc_decode (
    input  vt52tc_pkg::t_char i_ch,
    input  vt52tc_pkg::t_row  i_row,
    input  vt52tc_pkg::t_col  i_col,
    input  logic [1:0]        i_esc,
    output vt52tc_pkg::t_step o_step
);

    vt52tc_pkg::t_addr w_base;
    vt52tc_pkg::t_addr w_here;
    vt52tc_pkg::t_addr w_row_end;
    logic [7:0]        w_v;
    vt52tc_pkg::t_row  w_v_row;
    vt52tc_pkg::t_col  w_v_col;
    logic [6:0]        w_tab;
    vt52tc_pkg::t_col  w_tab_col;
    vt52tc_pkg::t_sweep_req w_scroll;

    assign w_base    = vt52tc_pkg::cell_addr(i_row, '0);
    assign w_here    = vt52tc_pkg::cell_addr(i_row, i_col);
    assign w_row_end = vt52tc_pkg::cell_addr(i_row, vt52tc_pkg::COL_LAST);

    // Y addressing byte, 8-bit wrap, clamped to the screen
    assign w_v     = {1'b0, i_ch} - vt52tc_pkg::ADDR_BIAS;
    assign w_v_row = (int'(w_v) >= vt52tc_pkg::ROWS) ? vt52tc_pkg::ROW_LAST
                                                     : vt52tc_pkg::t_row'(w_v);
    assign w_v_col = (int'(w_v) >= vt52tc_pkg::COLS) ? vt52tc_pkg::COL_LAST
                                                     : vt52tc_pkg::t_col'(w_v);

    assign w_tab     = ({1'b0, i_col} & vt52tc_pkg::TAB_MASK) + vt52tc_pkg::TAB_STEP;
    assign w_tab_col = (int'(w_tab) >= vt52tc_pkg::COLS) ? vt52tc_pkg::COL_LAST
                                                         : vt52tc_pkg::t_col'(w_tab);

    // one-line scroll: rows 1.. move up, last row cleared
    always_comb begin
        w_scroll         = '0;
        w_scroll.copy_en = 1'b1;
        w_scroll.copy_lo = vt52tc_pkg::t_addr'(vt52tc_pkg::COLS);
        w_scroll.copy_hi = vt52tc_pkg::ADDR_LAST;
        w_scroll.offset  = vt52tc_pkg::t_addr'(vt52tc_pkg::COLS);
        w_scroll.zero_lo = vt52tc_pkg::LAST_ROW_BASE;
        w_scroll.zero_hi = vt52tc_pkg::ADDR_LAST;
    end

    always_comb begin
        o_step     = '0;
        o_step.row = i_row;
        o_step.col = i_col;
        o_step.esc = i_esc;
        case (i_esc)
            vt52tc_pkg::ESC_ROW: begin
                o_step.row = w_v_row;
                o_step.esc = vt52tc_pkg::ESC_COL;
            end
            vt52tc_pkg::ESC_COL: begin
                o_step.col = w_v_col;
                o_step.esc = vt52tc_pkg::ESC_NORMAL;
            end
            vt52tc_pkg::ESC_START: begin
                o_step.esc = vt52tc_pkg::ESC_NORMAL;
                case (i_ch)
                    vt52tc_pkg::CH_ADDR: o_step.esc = vt52tc_pkg::ESC_ROW;
                    vt52tc_pkg::CH_UP: begin
                        if (i_row != '0) o_step.row = i_row - vt52tc_pkg::t_row'(1);
                    end
                    vt52tc_pkg::CH_DOWN: begin
                        if (i_row != vt52tc_pkg::ROW_LAST) begin
                            o_step.row = i_row + vt52tc_pkg::t_row'(1);
                        end
                    end
                    vt52tc_pkg::CH_RIGHT: begin
                        if (i_col != vt52tc_pkg::COL_LAST) begin
                            o_step.col = i_col + vt52tc_pkg::t_col'(1);
                        end
                    end
                    vt52tc_pkg::CH_LEFT: begin
                        if (i_col != '0) o_step.col = i_col - vt52tc_pkg::t_col'(1);
                    end
                    vt52tc_pkg::CH_HOME: begin
                        o_step.row = '0;
                        o_step.col = '0;
                    end
                    vt52tc_pkg::CH_ERS_S: begin
                        o_step.sweep       = 1'b1;
                        o_step.req.zero_lo = w_here;
                        o_step.req.zero_hi = vt52tc_pkg::ADDR_LAST;
                    end
                    vt52tc_pkg::CH_ERS_L: begin
                        o_step.sweep       = 1'b1;
                        o_step.req.zero_lo = w_here;
                        o_step.req.zero_hi = w_row_end;
                    end
                    default: ;
                endcase
            end
            default: begin
                case (i_ch)
                    vt52tc_pkg::CH_BS: begin
                        // pull the rest of the row left, blank the last cell
                        o_step.sweep       = 1'b1;
                        o_step.req.copy_en = 1'b1;
                        o_step.req.copy_lo = (i_col == '0)
                            ? w_base + vt52tc_pkg::t_addr'(1) : w_here;
                        o_step.req.copy_hi = w_row_end;
                        o_step.req.offset  = vt52tc_pkg::t_addr'(1);
                        o_step.req.zero_lo = w_row_end;
                        o_step.req.zero_hi = w_row_end;
                        if (i_col != '0) begin
                            o_step.col = i_col - vt52tc_pkg::t_col'(1);
                        end else if (i_row != '0) begin
                            o_step.row = i_row - vt52tc_pkg::t_row'(1);
                            o_step.col = vt52tc_pkg::COL_LAST;
                        end
                    end
                    vt52tc_pkg::CH_TAB: o_step.col = w_tab_col;
                    vt52tc_pkg::CH_LF: begin
                        o_step.col = '0;
                        if (i_row == vt52tc_pkg::ROW_LAST) begin
                            o_step.sweep = 1'b1;
                            o_step.req   = w_scroll;
                        end else begin
                            o_step.row = i_row + vt52tc_pkg::t_row'(1);
                        end
                    end
                    vt52tc_pkg::CH_CR:  o_step.col = '0;
                    vt52tc_pkg::CH_ESC: o_step.esc = vt52tc_pkg::ESC_START;
                    default: begin
                        if (i_ch >= vt52tc_pkg::CH_SPACE && i_ch != vt52tc_pkg::CH_DEL) begin
                            o_step.wr = 1'b1;
                            if (i_col != vt52tc_pkg::COL_LAST) begin
                                o_step.col = i_col + vt52tc_pkg::t_col'(1);
                            end else begin
                                o_step.col = '0;
                                if (i_row == vt52tc_pkg::ROW_LAST) begin
                                    o_step.sweep = 1'b1;
                                    o_step.req   = w_scroll;
                                end else begin
                                    o_step.row = i_row + vt52tc_pkg::t_row'(1);
                                end
                            end
                        end
                    end
                endcase
            end
        endcase
    end

endmodule

FILE: src/vt52tc_sweep.sv
// ----------------------------------------------------------------------------
// vt52tc_sweep
// Memory walker: optional block move toward lower addresses, then block clear.
// Comes out of reset clearing the whole screen.
// ----------------------------------------------------------------------------
module vt52tc_sweep (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  vt52tc_pkg::t_sweep_req i_req,
    input  vt52tc_pkg::t_char      i_rdata,
    output vt52tc_pkg::t_mem_port  o_mem,
    output logic                   o_busy
);

    `include "vt52_text_terminal_core_top_macros.svh"

    typedef enum logic [3:0] {
        SW_IDLE  = 4'b0001,
        SW_COPY  = 4'b0010,
        SW_FLUSH = 4'b0100,
        SW_ZERO  = 4'b1000
    } t_phase;

    t_phase            r_phase, n_phase;
    vt52tc_pkg::t_addr r_ptr, n_ptr;
    vt52tc_pkg::t_addr r_hi, n_hi;
    vt52tc_pkg::t_addr r_off, n_off;
    vt52tc_pkg::t_addr r_zlo, n_zlo;
    vt52tc_pkg::t_addr r_zhi, n_zhi;
    logic              r_wb_valid, n_wb_valid;
    vt52tc_pkg::t_addr r_wb_addr, n_wb_addr;

    always_comb begin
        n_phase    = r_phase;
        n_ptr      = r_ptr;
        n_hi       = r_hi;
        n_off      = r_off;
        n_zlo      = r_zlo;
        n_zhi      = r_zhi;
        n_wb_valid = 1'b0;
        n_wb_addr  = r_wb_addr;
        case (r_phase)
            SW_IDLE: begin
                if (i_start) begin
                    n_hi  = i_req.copy_hi;
                    n_off = i_req.offset;
                    n_zlo = i_req.zero_lo;
                    n_zhi = i_req.zero_hi;
                    if (i_req.copy_en) begin
                        n_phase = SW_COPY;
                        n_ptr   = i_req.copy_lo;
                    end else begin
                        n_phase = SW_ZERO;
                        n_ptr   = i_req.zero_lo;
                    end
                end
            end
            SW_COPY: begin
                // read source now, write it to the destination in the next cycle
                n_wb_valid = 1'b1;
                n_wb_addr  = r_ptr - r_off;
                if (r_ptr == r_hi) begin
                    n_phase = SW_FLUSH;
                end else begin
                    n_ptr = r_ptr + vt52tc_pkg::t_addr'(1);
                end
            end
            SW_FLUSH: begin
                n_phase = SW_ZERO;
                n_ptr   = r_zlo;
            end
            SW_ZERO: begin
                if (r_ptr == r_zhi) begin
                    n_phase = SW_IDLE;
                end else begin
                    n_ptr = r_ptr + vt52tc_pkg::t_addr'(1);
                end
            end
            default: n_phase = SW_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= SW_ZERO;
            r_ptr      <= '0;
            r_zhi      <= vt52tc_pkg::ADDR_LAST;
            r_wb_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ptr      <= n_ptr;
            r_zhi      <= n_zhi;
            r_wb_valid <= n_wb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi      <= n_hi;
        r_off     <= n_off;
        r_zlo     <= n_zlo;
        r_wb_addr <= n_wb_addr;
    end

    always_comb begin
        o_mem.raddr = r_ptr;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_ptr;
        o_mem.wdata = '0;
        if (r_wb_valid) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = r_wb_addr;
            o_mem.wdata = i_rdata;
        end else if (r_phase == SW_ZERO) begin
            o_mem.we = 1'b1;
        end
    end

    assign o_busy = (r_phase != SW_IDLE);

    `VT52TC_ASSERT_SAME(a_zero_writes_blank, r_phase == SW_ZERO, o_mem.we && (o_mem.wdata == '0), "clear phase must write blanks")
    `VT52TC_ASSERT_SAME(a_move_no_overlap, r_wb_valid, o_mem.waddr != o_mem.raddr, "move write hits the cell being read")
    `VT52TC_ASSERT_NEXT(a_flush_to_zero, r_phase == SW_FLUSH, (r_phase == SW_ZERO) && !r_wb_valid, "flush must hand over to clear")

endmodule

FILE: src/vt52_text_terminal_core_top.sv
// ----------------------------------------------------------------------------
// vt52_text_terminal_core_top
// VT52-style character-cell terminal core: screen memory, cursor, escapes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  i_in    | in  | valid/ready       | cmd, char_code, read_row, read_col
//  o_out   | out | valid/ready       | cursor_row, cursor_col, cell_data,
//          |     |                   | escape_phase
//
//  Flow: a plain character, cursor move or escape byte is accepted in
//  S_IDLE, then S_HOLD loads its result into o_out; a cell read goes
//  through S_READ (one registered RAM read) before S_HOLD.
//  Backspace, erase and scroll walk the screen RAM one cell a cycle through
//  its single write port: an erase only clears cells; backspace and scroll
//  first move cells toward lower addresses, then clear.
//  Reset: after i_rst_n the whole screen RAM is cleared, ROWS*COLS cycles
//  (2048) plus one, with i_in.ready low.
//  Stalls: one word is in work at a time; a finished result waits in a
//  holding register while o_out still holds the previous one.
// ----------------------------------------------------------------------------
module vt52_text_terminal_core_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vt52tc_in_if.sink    i_in,
    vt52tc_out_if.source o_out
);

    `include "vt52_text_terminal_core_top_macros.svh"

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,  // power-up wipe of the screen RAM
        S_IDLE  = 5'b00010,  // ready for a word
        S_READ  = 5'b00100,  // cell read in flight
        S_SWEEP = 5'b01000,  // move/clear walk running
        S_HOLD  = 5'b10000   // result waits for the output register
    } t_state;

    t_state           r_state, n_state;
    vt52tc_pkg::t_row r_cur_row, n_cur_row;
    vt52tc_pkg::t_col r_cur_col, n_cur_col;
    logic [1:0]       r_esc, n_esc;

    // result holding register
    vt52tc_pkg::t_row  r_res_row, n_res_row;
    vt52tc_pkg::t_col  r_res_col, n_res_col;
    vt52tc_pkg::t_char r_res_data, n_res_data;
    logic [1:0]        r_res_esc, n_res_esc;

    // output register
    logic              r_out_valid, n_out_valid;
    vt52tc_pkg::t_row  r_out_row;
    vt52tc_pkg::t_col  r_out_col;
    vt52tc_pkg::t_char r_out_data;
    logic [1:0]        r_out_esc;

    logic                  w_accept;
    logic                  w_load_out;
    logic                  w_in_range;
    vt52tc_pkg::t_char     w_ch;
    vt52tc_pkg::t_step     w_step;
    logic                  w_sweep_start;
    logic                  w_sweep_busy;
    vt52tc_pkg::t_mem_port w_sweep_mem;
    vt52tc_pkg::t_mem_port w_ram;
    vt52tc_pkg::t_char     w_rdata;

    assign w_ch       = i_in.char_code[vt52tc_pkg::CHAR_W-1:0];
    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_in_range = (int'(i_in.read_row) < vt52tc_pkg::ROWS)
                     && (int'(i_in.read_col) < vt52tc_pkg::COLS);

    vt52tc_decode u_decode (
        .i_ch   (w_ch),
        .i_row  (r_cur_row),
        .i_col  (r_cur_col),
        .i_esc  (r_esc),
        .o_step (w_step)
    );

    assign w_sweep_start = w_accept && !i_in.cmd && w_step.sweep;

    vt52tc_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sweep_start),
        .i_req   (w_step.req),
        .i_rdata (w_rdata),
        .o_mem   (w_sweep_mem),
        .o_busy  (w_sweep_busy)
    );

    // RAM port: the walker owns it while busy; otherwise the cursor write
    // of a printable character and the cell read of a read word
    always_comb begin
        if (w_sweep_busy) begin
            w_ram = w_sweep_mem;
        end else begin
            w_ram.we    = w_accept && !i_in.cmd && w_step.wr;
            w_ram.waddr = vt52tc_pkg::cell_addr(r_cur_row, r_cur_col);
            w_ram.wdata = w_ch;
            w_ram.raddr = vt52tc_pkg::cell_addr(i_in.read_row, i_in.read_col);
        end
    end

    vt52tc_ram #(
        .DEPTH (vt52tc_pkg::DEPTH),
        .WIDTH (vt52tc_pkg::CHAR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    assign w_load_out = (r_state == S_HOLD) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_esc       = r_esc;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_res_data  = r_res_data;
        n_res_esc   = r_res_esc;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_CLEAR: begin
                if (!w_sweep_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.cmd) begin
                        // a read leaves all state alone
                        n_res_row  = r_cur_row;
                        n_res_col  = r_cur_col;
                        n_res_esc  = r_esc;
                        n_res_data = '0;
                        n_state    = w_in_range ? S_READ : S_HOLD;
                    end else begin
                        n_cur_row  = w_step.row;
                        n_cur_col  = w_step.col;
                        n_esc      = w_step.esc;
                        n_res_row  = w_step.row;
                        n_res_col  = w_step.col;
                        n_res_esc  = w_step.esc;
                        n_res_data = '0;
                        n_state    = w_step.sweep ? S_SWEEP : S_HOLD;
                    end
                end
            end
            S_READ: begin
                n_res_data = w_rdata;
                n_state    = S_HOLD;
            end
            S_SWEEP: begin
                if (!w_sweep_busy) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_esc       <= vt52tc_pkg::ESC_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_esc       <= n_esc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_row  <= n_res_row;
        r_res_col  <= n_res_col;
        r_res_data <= n_res_data;
        r_res_esc  <= n_res_esc;
        if (w_load_out) begin
            r_out_row  <= r_res_row;
            r_out_col  <= r_res_col;
            r_out_data <= r_res_data;
            r_out_esc  <= r_res_esc;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cursor_row   = r_out_row;
    assign o_out.cursor_col   = r_out_col;
    assign o_out.cell_data    = r_out_data;
    assign o_out.escape_phase = r_out_esc;

    `VT52TC_ASSERT_SAME(a_accept_walker_idle, i_in.valid && i_in.ready, !w_sweep_busy, "word accepted while walker busy")
    `VT52TC_ASSERT_SAME(a_cursor_on_screen, 1'b1, (int'(r_cur_row) < vt52tc_pkg::ROWS) && (int'(r_cur_col) < vt52tc_pkg::COLS), "cursor off screen")
    `VT52TC_ASSERT_NEXT(a_walk_done_to_hold, (r_state == S_SWEEP) && !w_sweep_busy, r_state == S_HOLD, "walk end must post a result")

endmodule
